// ----- rtl/hsfu_pkg.sv -----
`default_nettype none

package hsfu_pkg;

  // Default sizes of the factor tables.
  localparam int NODES_DEF = 256;
  localparam int DIM_DEF   = 8;

  // Command codes.
  localparam logic [2:0] CMD_WRITE_U  = 3'd0;
  localparam logic [2:0] CMD_WRITE_V  = 3'd1;
  localparam logic [2:0] CMD_TRAIN    = 3'd2;
  localparam logic [2:0] CMD_EVALUATE = 3'd3;
  localparam logic [2:0] CMD_READ_U   = 3'd4;
  localparam logic [2:0] CMD_READ_V   = 3'd5;
  // Unused command codes; they change nothing and return zeros.
  localparam logic [2:0] CMD_SPARE_A  = 3'd6;
  localparam logic [2:0] CMD_SPARE_B  = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] CFG_STEP_SIZE      = 3'd0;
  localparam logic [2:0] CFG_HUBER_WIDTH    = 3'd1;
  localparam logic [2:0] CFG_L2_WEIGHT      = 3'd2;
  localparam logic [2:0] CFG_L1_WEIGHT      = 3'd3;
  localparam logic [2:0] CFG_SYMMETRIC_MODE = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] STEP_SIZE_RST   = 16'd655;
  localparam logic [30:0] HUBER_WIDTH_RST = 31'd65536;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         row_node;
    logic [7:0]         col_node;
    logic [2:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] measured_value;
    logic               last_sample;
  } request_t;

  typedef struct packed {
    logic signed [31:0] factor_value;
    logic signed [31:0] prediction_value;
    logic [47:0]        loss_value;
  } result_t;

  // Saturate a 38-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
    logic ok;
    ok = (&x[37:31]) | ~(|x[37:31]);
    if (ok) begin
      sat32 = x[31:0];
    end else if (x[37]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/huber_sgd_factor_update_core.sv -----
`default_nettype none

// Huber-loss SGD factor update core. The factor tables U and V live in two
// single-port-write RAMs of NODES*DIM words; a command is taken when start is
// high and busy is low, and exactly one result follows, shown for a single
// cycle with result_valid high; the receiver cannot stall it. Every command
// first reduces out-of-range node and column ids one subtraction of NODES (or
// DIM) at a time. Train and evaluate read one U and one V word per term through
// the read, multiply and accumulate states, over DIM terms (twice as many in
// symmetric mode), then form the error; when the error lies inside the Huber
// width, a shared bit-serial divider yields the loss and then the gradient at
// one quotient bit a cycle. Train then rewrites both rows, one column per pass
// through the read, multiply and write states, and again with the rows swapped
// in symmetric mode.
module huber_sgd_factor_update_core
  import hsfu_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int DIM   = DIM_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire request_t    request,
  output logic             result_valid,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW    = $clog2(NODES * DIM);
  localparam int KW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ACC_W = 49 + $clog2(2 * DIM);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_NORM   = 14'b00000000000010,
    S_ACCESS = 14'b00000000000100,
    S_FINISH = 14'b00000000001000,
    S_P_RD   = 14'b00000000010000,
    S_P_MUL  = 14'b00000000100000,
    S_P_ACC  = 14'b00000001000000,
    S_ERR    = 14'b00000010000000,
    S_SQ     = 14'b00000100000000,
    S_DIV    = 14'b00001000000000,
    S_U_RD   = 14'b00010000000000,
    S_U_M1   = 14'b00100000000000,
    S_U_M2   = 14'b01000000000000,
    S_U_WR   = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration.
  logic [15:0] step_size;
  logic [30:0] huber_width;
  logic [15:0] l2_weight;
  logic [15:0] l1_weight;
  logic        symmetric_mode;
  logic [47:0] loss_total;

  // Request and sequencing.
  request_t       req;
  logic [7:0]     rn;
  logic [7:0]     cn;
  logic [2:0]     ei;
  logic [KW-1:0]  k;
  logic           swap;

  // Prediction and Huber terms.
  logic signed [63:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]    pred;
  logic [32:0]           ax;
  logic                  x_neg;
  logic [32:0]           f;
  logic signed [17:0]    g;

  // Divider.
  logic [31:0] rem;
  logic [31:0] dq;
  logic [31:0] div_d;
  logic [4:0]  div_cnt;
  logic        div_g;

  // Update pipeline.
  logic signed [31:0] u0;
  logic signed [31:0] v0;
  logic signed [49:0] gv;
  logic signed [49:0] gu;
  logic signed [49:0] l2u;
  logic signed [49:0] l2v;
  logic signed [52:0] su;
  logic signed [52:0] sv;

  // Memory ports.
  logic          u_we;
  logic          v_we;
  logic [31:0]   u_wdata;
  logic [31:0]   v_wdata;
  logic [31:0]   u_rdata;
  logic [31:0]   v_rdata;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] v_addr;

  // Combinational helpers.
  logic [30:0]          lam;
  logic [7:0]           node_x;
  logic [7:0]           node_y;
  logic [KW-1:0]        col;
  logic                 k_last;
  logic                 acc_ok;
  logic signed [31:0]   pv_c;
  logic signed [32:0]   x_c;
  logic [32:0]          ax_c;
  logic [61:0]          sq;
  logic [32:0]          div_t;
  logic                 div_ge;
  logic [31:0]          dq_next;
  logic signed [17:0]   l1u;
  logic signed [17:0]   l1v;
  logic signed [35:0]   du;
  logic signed [35:0]   dv;
  logic signed [17:0]   l2s;
  logic signed [16:0]   lrs;
  logic signed [31:0]   new_u;
  logic signed [31:0]   new_v;
  logic [48:0]          loss_sum;
  logic [47:0]          loss_sat;
  result_t              result_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign lam       = (huber_width == 31'd0) ? 31'd1 : huber_width;
  assign k_last    = (k == KW'(DIM - 1));

  // Row and column addresses of the current term.
  assign node_x = swap ? cn : rn;
  assign node_y = swap ? rn : cn;
  assign col    = (state == S_ACCESS) ? KW'(ei) : k;
  assign addr_a = AW'(node_x) * AW'(DIM) + AW'(col);
  assign addr_b = AW'(node_y) * AW'(DIM) + AW'(col);
  assign v_addr = (state == S_ACCESS) ? addr_a : addr_b;

  // Full square of the error; inside the Huber width the error fits 31 bits.
  assign sq = 62'(ax[30:0]) * 62'(ax[30:0]);

  // Saturated prediction and its error against the measurement.
  always_comb begin
    acc_ok = (&acc[ACC_W-1:31]) | ~(|acc[ACC_W-1:31]);
    if (acc_ok) begin
      pv_c = acc[31:0];
    end else if (acc[ACC_W-1]) begin
      pv_c = 32'sh8000_0000;
    end else begin
      pv_c = 32'sh7FFF_FFFF;
    end
    x_c  = 33'(pv_c) - 33'(req.measured_value);
    ax_c = x_c[32] ? 33'(-x_c) : 33'(x_c);
  end

  // One restoring division step.
  always_comb begin
    div_t   = {rem, dq[31]};
    div_ge  = (div_t >= {1'b0, div_d});
    dq_next = {dq[30:0], div_ge};
  end

  // Regularized step terms for one column.
  always_comb begin
    l2s = $signed({1'b0, l2_weight, 1'b0});
    lrs = $signed({1'b0, step_size});
    if (u0 > 32'sd0) begin
      l1u = $signed({2'b00, l1_weight});
    end else if (u0 < 32'sd0) begin
      l1u = -$signed({2'b00, l1_weight});
    end else begin
      l1u = 18'sd0;
    end
    if (v0 > 32'sd0) begin
      l1v = $signed({2'b00, l1_weight});
    end else if (v0 < 32'sd0) begin
      l1v = -$signed({2'b00, l1_weight});
    end else begin
      l1v = 18'sd0;
    end
    du    = -36'(gv >>> 16) - 36'(l1u) - 36'(l2u >>> 16);
    dv    = -36'(gu >>> 16) - 36'(l1v) - 36'(l2v >>> 16);
    new_u = sat32(38'(u0) + 38'(su >>> 16));
    new_v = sat32(38'(v0) + 38'(sv >>> 16));
  end

  // Memory write selection.
  always_comb begin
    u_we    = ((state == S_ACCESS) && (req.command == CMD_WRITE_U)) || (state == S_U_WR);
    v_we    = ((state == S_ACCESS) && (req.command == CMD_WRITE_V)) || (state == S_U_WR);
    u_wdata = (state == S_ACCESS) ? req.element_value : new_u;
    v_wdata = (state == S_ACCESS) ? req.element_value : new_v;
  end

  // Result and running loss.
  always_comb begin
    loss_sum    = {1'b0, loss_total} + 49'(f);
    loss_sat    = loss_sum[48] ? 48'hFFFF_FFFF_FFFF : loss_sum[47:0];
    result_next = '0;
    case (req.command)
      CMD_READ_U: begin
        result_next.factor_value = u_rdata;
      end
      CMD_READ_V: begin
        result_next.factor_value = v_rdata;
      end
      CMD_TRAIN: begin
        result_next.prediction_value = pred;
      end
      CMD_EVALUATE: begin
        result_next.prediction_value = pred;
        result_next.loss_value       = loss_sat;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  hsfu_ram #(.WIDTH(32), .DEPTH(NODES * DIM)) u_ram_u (
    .clk   (clk),
    .we    (u_we),
    .waddr (addr_a),
    .wdata (u_wdata),
    .raddr (addr_a),
    .rdata (u_rdata)
  );

  hsfu_ram #(.WIDTH(32), .DEPTH(NODES * DIM)) u_ram_v (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_addr),
    .wdata (v_wdata),
    .raddr (v_addr),
    .rdata (v_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= STEP_SIZE_RST;
      huber_width    <= HUBER_WIDTH_RST;
      l2_weight      <= '0;
      l1_weight      <= '0;
      symmetric_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_SIZE:      step_size      <= cfg_data[15:0];
        CFG_HUBER_WIDTH:    huber_width    <= cfg_data[30:0];
        CFG_L2_WEIGHT:      l2_weight      <= cfg_data[15:0];
        CFG_L1_WEIGHT:      l1_weight      <= cfg_data[15:0];
        CFG_SYMMETRIC_MODE: symmetric_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      loss_total   <= '0;
    end else begin
      result_valid <= (state == S_FINISH);
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (32'(rn) >= 32'(NODES)) begin
            state <= S_NORM;
          end else if (32'(cn) >= 32'(NODES)) begin
            state <= S_NORM;
          end else if (32'(ei) >= 32'(DIM)) begin
            state <= S_NORM;
          end else if ((req.command == CMD_TRAIN) || (req.command == CMD_EVALUATE)) begin
            state <= S_P_RD;
          end else begin
            state <= S_ACCESS;
          end
        end
        S_ACCESS: state <= S_FINISH;
        S_FINISH: begin
          if (req.command == CMD_EVALUATE) begin
            loss_total <= req.last_sample ? 48'd0 : loss_sat;
          end
          state <= S_IDLE;
        end
        S_P_RD:  state <= S_P_MUL;
        S_P_MUL: state <= S_P_ACC;
        S_P_ACC: begin
          if (k_last && !(symmetric_mode && !swap)) begin
            state <= S_ERR;
          end else begin
            state <= S_P_RD;
          end
        end
        S_ERR: begin
          if (ax_c < {2'b00, lam}) begin
            state <= S_SQ;
          end else if (req.command == CMD_TRAIN) begin
            state <= S_U_RD;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SQ: state <= S_DIV;
        S_DIV: begin
          if ((div_cnt == 5'd31) && div_g) begin
            state <= (req.command == CMD_TRAIN) ? S_U_RD : S_FINISH;
          end
        end
        S_U_RD: state <= S_U_M1;
        S_U_M1: state <= S_U_M2;
        S_U_M2: state <= S_U_WR;
        S_U_WR: begin
          if (k_last && !(symmetric_mode && !swap)) begin
            state <= S_FINISH;
          end else begin
            state <= S_U_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      result <= result_next;
    end
    case (state)
      S_IDLE: begin
        req  <= request;
        rn   <= request.row_node;
        cn   <= request.col_node;
        ei   <= request.element_index;
        k    <= '0;
        swap <= 1'b0;
        acc  <= '0;
        f    <= '0;
      end
      S_NORM: begin
        // Reduce node and column ids one subtraction at a time.
        if (32'(rn) >= 32'(NODES)) begin
          rn <= rn - 8'(NODES);
        end else if (32'(cn) >= 32'(NODES)) begin
          cn <= cn - 8'(NODES);
        end else if (32'(ei) >= 32'(DIM)) begin
          ei <= ei - 3'(DIM);
        end
      end
      S_P_MUL: begin
        prod <= 64'($signed(u_rdata)) * 64'($signed(v_rdata));
      end
      S_P_ACC: begin
        acc <= acc + {{(ACC_W-48){prod[63]}}, prod[63:16]};
        if (k_last) begin
          k    <= '0;
          swap <= symmetric_mode && !swap;
        end else begin
          k <= k + KW'(1);
        end
      end
      S_ERR: begin
        pred  <= pv_c;
        ax    <= ax_c;
        x_neg <= x_c[32];
        f     <= ax_c - 33'(lam >> 1);
        g     <= x_c[32] ? -18'sd65536 : 18'sd65536;
      end
      S_SQ: begin
        // Square of the error feeds the loss division by twice the width.
        rem     <= {2'b00, sq[61:32]};
        dq      <= sq[31:0];
        div_d   <= {lam, 1'b0};
        div_cnt <= '0;
        div_g   <= 1'b0;
      end
      S_DIV: begin
        div_cnt <= div_cnt + 5'd1;
        if ((div_cnt == 5'd31) && !div_g) begin
          // Loss quotient done: start the gradient x*65536/lambda.
          f     <= 33'(dq_next);
          rem   <= 32'(ax[32:16]);
          dq    <= {ax[15:0], 16'd0};
          div_d <= 32'(lam);
          div_g <= 1'b1;
        end else begin
          rem <= div_ge ? 32'(div_t - {1'b0, div_d}) : div_t[31:0];
          dq  <= dq_next;
          if (div_cnt == 5'd31) begin
            g <= x_neg ? -$signed({1'b0, dq_next[16:0]}) : $signed({1'b0, dq_next[16:0]});
          end
        end
      end
      S_U_M1: begin
        u0  <= u_rdata;
        v0  <= v_rdata;
        gv  <= 50'(g) * 50'($signed(v_rdata));
        gu  <= 50'(g) * 50'($signed(u_rdata));
        l2u <= 50'(l2s) * 50'($signed(u_rdata));
        l2v <= 50'(l2s) * 50'($signed(v_rdata));
      end
      S_U_M2: begin
        su <= 53'(du) * 53'(lrs);
        sv <= 53'(dv) * 53'(lrs);
      end
      S_U_WR: begin
        if (k_last) begin
          k    <= '0;
          swap <= symmetric_mode && !swap;
        end else begin
          k <= k + KW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/hsfu_ram.sv -----
`default_nettype none

module hsfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/hsfu_checker.sv -----
`default_nettype none

module hsfu_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid
);

  // A result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result is shown only once the block is free again.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  // Busy only starts after a request.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind huber_sgd_factor_update_core hsfu_checker u_hsfu_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid)
);

`default_nettype wire
